// ===== rtl/core/gced_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad capture event detector package
// Shared constants, codes and word types for the capture event detector.
// ----------------------------------------------------------------------------
package gced_pkg;

   localparam int AXIS_FIELDS      = 6;
   localparam int NUM_BUTTONS_DEF  = 32;
   localparam int NUM_AXES_DEF     = 6;

   localparam logic [15:0] HAT_CENTRED     = 16'hFFFF;
   localparam logic [15:0] AXIS_CENTER_RST = 16'd32767;
   localparam logic [15:0] DEAD_ZONE_RST   = 16'd12000;

   localparam logic [15:0] HAT_UP_LOW      = 16'd4500;
   localparam logic [15:0] HAT_RIGHT_LOW   = 16'd13500;
   localparam logic [15:0] HAT_DOWN_LOW    = 16'd22500;
   localparam logic [15:0] HAT_UP_HIGH     = 16'd31500;

   localparam logic [1:0] OP_POLL   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BUTTON = 2'd1;
   localparam logic [1:0] KIND_HAT    = 2'd2;
   localparam logic [1:0] KIND_AXIS   = 2'd3;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic CSR_AXIS_CENTER = 1'b0;
   localparam logic CSR_DEAD_ZONE   = 1'b1;

   typedef struct packed {
      logic [1:0]                    op;
      logic [31:0]                   buttons;
      logic [15:0]                   hat_angle;
      logic [AXIS_FIELDS-1:0][15:0]  axis;
   } sample_type;

   typedef struct packed {
      logic       event_valid;
      logic [1:0] event_kind;
      logic [5:0] button_number;
      logic [1:0] hat_direction;
      logic [2:0] axis_number;
      logic       axis_positive;
      logic       armed_now;
   } result_type;

endpackage

// ===== rtl/core/gced_in_stage.sv =====
// ----------------------------------------------------------------------------
// Capture detector input stage
// Registers one request word and holds it while the detector stalls.
// ----------------------------------------------------------------------------
module gced_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gced_pkg::sample_type req_word,
   output logic               s1_valid,
   output gced_pkg::sample_type s1_word,
   input  logic               s1_stall
);

   logic                 valid_ff;
   gced_pkg::sample_type word_ff;

   assign req_stall = valid_ff && s1_stall;
   assign s1_valid  = valid_ff;
   assign s1_word   = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         word_ff <= req_word;
      end
   end

endmodule

// ===== rtl/core/gced_axis_cmp.sv =====
// ----------------------------------------------------------------------------
// Capture detector axis compare
// Per-axis distance from centre against the dead zone, plus the axis sign.
// ----------------------------------------------------------------------------
module gced_axis_cmp (
   input  logic [gced_pkg::AXIS_FIELDS-1:0][15:0] axis,
   input  logic [15:0]                            axis_center,
   input  logic [15:0]                            dead_zone,
   output logic [gced_pkg::AXIS_FIELDS-1:0]       outside,
   output logic [gced_pkg::AXIS_FIELDS-1:0]       above
);

   for (genvar g = 0; g < gced_pkg::AXIS_FIELDS; g++) begin : g_lane
      logic [15:0] span;
      assign above[g]   = axis[g] > axis_center;
      assign span       = above[g] ? (axis[g] - axis_center) : (axis_center - axis[g]);
      assign outside[g] = span > dead_zone;
   end

endmodule

// ===== rtl/core/gced_core.sv =====
// ----------------------------------------------------------------------------
// Capture detector core
// Capture state, event priority selection and the result register.
// ----------------------------------------------------------------------------
module gced_core #(
   parameter int NUM_BUTTONS = gced_pkg::NUM_BUTTONS_DEF,
   parameter int NUM_AXES    = gced_pkg::NUM_AXES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  gced_pkg::sample_type              in_word,
   output logic                              in_stall,
   input  logic [gced_pkg::AXIS_FIELDS-1:0]  outside,
   input  logic [gced_pkg::AXIS_FIELDS-1:0]  above,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gced_pkg::result_type              rsp_word
);

   localparam int AXES_USED = (NUM_AXES < gced_pkg::AXIS_FIELDS) ?
                              NUM_AXES : gced_pkg::AXIS_FIELDS;

   logic                    armed_ff, armed_in;
   logic [NUM_BUTTONS-1:0]  last_buttons_ff, last_buttons_in;
   logic [15:0]             last_hat_ff, last_hat_in;
   logic [NUM_AXES-1:0]     flag_ff, flag_in;
   logic                    rsp_valid_ff;
   gced_pkg::result_type    rsp_word_ff, rsp_word_in;

   logic                    take;
   logic                    poll;
   logic [NUM_BUTTONS-1:0]  cur;
   logic [NUM_BUTTONS-1:0]  pressed;
   logic [5:0]              btn_idx;
   logic                    hat_ev;
   logic [1:0]              hat_dir;
   logic                    axis_phase;
   logic                    axis_hit;
   logic [2:0]              hit_idx;
   logic                    hit_above;

   assign in_stall  = in_valid && rsp_valid_ff && rsp_stall;
   assign take      = in_valid && !in_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign poll    = (in_word.op == gced_pkg::OP_POLL) && armed_ff;
   assign cur     = in_word.buttons[NUM_BUTTONS-1:0];
   assign pressed = cur & ~last_buttons_ff;

   always_comb begin
      btn_idx = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (pressed[i]) btn_idx = 6'(i);
      end
   end

   assign hat_ev = (in_word.hat_angle != last_hat_ff) &&
                   (in_word.hat_angle != gced_pkg::HAT_CENTRED);

   always_comb begin
      if (in_word.hat_angle < gced_pkg::HAT_UP_LOW ||
          in_word.hat_angle > gced_pkg::HAT_UP_HIGH) begin
         hat_dir = gced_pkg::DIR_UP;
      end else if (in_word.hat_angle < gced_pkg::HAT_RIGHT_LOW) begin
         hat_dir = gced_pkg::DIR_RIGHT;
      end else if (in_word.hat_angle < gced_pkg::HAT_DOWN_LOW) begin
         hat_dir = gced_pkg::DIR_DOWN;
      end else begin
         hat_dir = gced_pkg::DIR_LEFT;
      end
   end

   assign axis_phase = poll && (pressed == '0) && !hat_ev;

   always_comb begin
      axis_hit  = 1'b0;
      hit_idx   = '0;
      hit_above = 1'b0;
      for (int i = AXES_USED - 1; i >= 0; i--) begin
         if (outside[i] && !flag_ff[i]) begin
            axis_hit  = 1'b1;
            hit_idx   = 3'(i);
            hit_above = above[i];
         end
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_flag
      if (g < AXES_USED) begin : g_used
         always_comb begin
            if (!(take && axis_phase)) begin
               flag_in[g] = flag_ff[g];
            end else if (!axis_hit || 3'(g) < hit_idx) begin
               flag_in[g] = outside[g];
            end else if (3'(g) == hit_idx) begin
               flag_in[g] = 1'b1;
            end else begin
               flag_in[g] = flag_ff[g];
            end
         end
      end else begin : g_idle
         assign flag_in[g] = flag_ff[g];
      end
   end

   always_comb begin
      armed_in        = armed_ff;
      last_buttons_in = last_buttons_ff;
      last_hat_in     = last_hat_ff;
      rsp_word_in     = '0;
      case (in_word.op)
         gced_pkg::OP_ARM: begin
            armed_in        = 1'b1;
            last_buttons_in = '0;
         end
         gced_pkg::OP_CANCEL: begin
            armed_in = 1'b0;
         end
         gced_pkg::OP_POLL: begin
            if (armed_ff) begin
               last_buttons_in = cur;
               if (pressed != '0) begin
                  rsp_word_in.event_valid   = 1'b1;
                  rsp_word_in.event_kind    = gced_pkg::KIND_BUTTON;
                  rsp_word_in.button_number = btn_idx + 6'd1;
               end else begin
                  last_hat_in = in_word.hat_angle;
                  if (hat_ev) begin
                     rsp_word_in.event_valid   = 1'b1;
                     rsp_word_in.event_kind    = gced_pkg::KIND_HAT;
                     rsp_word_in.hat_direction = hat_dir;
                  end else if (axis_hit) begin
                     rsp_word_in.event_valid   = 1'b1;
                     rsp_word_in.event_kind    = gced_pkg::KIND_AXIS;
                     rsp_word_in.axis_number   = hit_idx;
                     rsp_word_in.axis_positive = hit_above;
                  end
               end
               if (rsp_word_in.event_valid) armed_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      rsp_word_in.armed_now = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         last_buttons_ff <= '0;
         last_hat_ff     <= gced_pkg::HAT_CENTRED;
         flag_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         flag_ff <= flag_in;
         if (take) begin
            armed_ff        <= armed_in;
            last_buttons_ff <= last_buttons_in;
            last_hat_ff     <= last_hat_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== rtl/core/gamepad_capture_event_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Gamepad capture event detector
// Reports the first new button, hat or axis event while capture is armed.
// ----------------------------------------------------------------------------
// Request channel (req_): one word per command - poll a sample, arm or
// cancel - with the button bitmap, hat angle and six axis values. A word
// is taken when req_valid is high and req_stall low.
// Result channel (rsp_): exactly one result word per request word, in
// order, taken when rsp_valid is high and rsp_stall low.
// The request passes through one input register, then the event selection
// into the result register. Throughput is one word per cycle while rsp_stall
// is low; the capture state updates in the same cycle as the result.
// A stalled result holds; the input register takes one more word behind
// it, after which req_stall rises until the result is taken.
// Reset disarms capture, clears stored buttons and axis flags, centres the
// stored hat and loads axis_center 32767 and dead_zone 12000.
// csr_ writes (index 0 axis centre, 1 dead zone) take effect at once. The
// user makes them while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module gamepad_capture_event_detector_unit #(
   parameter int NUM_BUTTONS = gced_pkg::NUM_BUTTONS_DEF,
   parameter int NUM_AXES    = gced_pkg::NUM_AXES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_buttons,
   input  logic [15:0] req_hat_angle,
   input  logic [15:0] req_axis_x,
   input  logic [15:0] req_axis_y,
   input  logic [15:0] req_axis_z,
   input  logic [15:0] req_axis_r,
   input  logic [15:0] req_axis_u,
   input  logic [15:0] req_axis_v,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_valid,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_button_number,
   output logic [1:0]  rsp_hat_direction,
   output logic [2:0]  rsp_axis_number,
   output logic        rsp_axis_positive,
   output logic        rsp_armed_now
);

   logic [15:0]                          axis_center_ff;
   logic [15:0]                          dead_zone_ff;
   gced_pkg::sample_type                 req_word;
   gced_pkg::sample_type                 s1_word;
   logic                                 s1_valid;
   logic                                 s1_stall;
   logic [gced_pkg::AXIS_FIELDS-1:0]     outside;
   logic [gced_pkg::AXIS_FIELDS-1:0]     above;
   gced_pkg::result_type                 rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_center_ff <= gced_pkg::AXIS_CENTER_RST;
         dead_zone_ff   <= gced_pkg::DEAD_ZONE_RST;
      end else if (csr_we) begin
         case (csr_index)
            gced_pkg::CSR_AXIS_CENTER: axis_center_ff <= csr_wdata;
            gced_pkg::CSR_DEAD_ZONE:   dead_zone_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_word.op        = req_op;
      req_word.buttons   = req_buttons;
      req_word.hat_angle = req_hat_angle;
      req_word.axis[0]   = req_axis_x;
      req_word.axis[1]   = req_axis_y;
      req_word.axis[2]   = req_axis_z;
      req_word.axis[3]   = req_axis_r;
      req_word.axis[4]   = req_axis_u;
      req_word.axis[5]   = req_axis_v;
   end

   gced_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .s1_stall  (s1_stall)
   );

   gced_axis_cmp u_axis_cmp (
      .axis        (s1_word.axis),
      .axis_center (axis_center_ff),
      .dead_zone   (dead_zone_ff),
      .outside     (outside),
      .above       (above)
   );

   gced_core #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .NUM_AXES    (NUM_AXES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_word   (s1_word),
      .in_stall  (s1_stall),
      .outside   (outside),
      .above     (above),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_event_valid   = rsp_word.event_valid;
   assign rsp_event_kind    = rsp_word.event_kind;
   assign rsp_button_number = rsp_word.button_number;
   assign rsp_hat_direction = rsp_word.hat_direction;
   assign rsp_axis_number   = rsp_word.axis_number;
   assign rsp_axis_positive = rsp_word.axis_positive;
   assign rsp_armed_now     = rsp_word.armed_now;

endmodule

// ===== test/gced_event_checker.sv =====
// ----------------------------------------------------------------------------
// Capture event checker
// Watches the request, result and register ports of the capture event
// detector, predicts one result word per accepted request word and compares
// every accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gced_event_checker
   import gced_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int NUM_AXES    = NUM_AXES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_buttons,
   input  logic [15:0] req_hat_angle,
   input  logic [15:0] req_axis_x,
   input  logic [15:0] req_axis_y,
   input  logic [15:0] req_axis_z,
   input  logic [15:0] req_axis_r,
   input  logic [15:0] req_axis_u,
   input  logic [15:0] req_axis_v,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_event_valid,
   input  logic [1:0]  rsp_event_kind,
   input  logic [5:0]  rsp_button_number,
   input  logic [1:0]  rsp_hat_direction,
   input  logic [2:0]  rsp_axis_number,
   input  logic        rsp_axis_positive,
   input  logic        rsp_armed_now,
   output int          events_pending,
   output int          mismatch_count
);

   localparam logic [31:0] BUTTON_MASK = (NUM_BUTTONS >= 32) ? 32'hFFFF_FFFF :
                                         ((32'd1 << NUM_BUTTONS) - 32'd1);
   localparam int AXES_SEEN = (NUM_AXES < AXIS_FIELDS) ? NUM_AXES : AXIS_FIELDS;

   logic [15:0]          centre;
   logic [15:0]          dead_zone;
   logic                 armed;
   logic [31:0]          held_buttons;
   logic [15:0]          held_hat;
   logic [AXIS_FIELDS-1:0] axis_flag;

   result_type           expected_events[$];
   sample_type           word_in;
   result_type           want;
   result_type           got;
   int                   errors = 0;

   initial begin
      events_pending = 0;
      mismatch_count = 0;
   end

   task automatic predict_event(input sample_type s, output result_type r);
      logic [31:0] cur;
      logic [31:0] fresh;
      logic [15:0] v;
      logic [15:0] span;
      logic        out_now;
      r = '0;
      case (s.op)
         OP_ARM: begin
            armed = 1'b1;
            held_buttons = '0;
         end
         OP_CANCEL: armed = 1'b0;
         OP_POLL: if (armed) begin
            cur = s.buttons & BUTTON_MASK;
            fresh = cur & ~held_buttons;
            held_buttons = cur;
            if (fresh != '0) begin
               r.event_valid = 1'b1;
               r.event_kind = KIND_BUTTON;
               for (int b = 31; b >= 0; b--) begin
                  if (fresh[b]) r.button_number = 6'(b + 1);
               end
            end else if (s.hat_angle != held_hat && s.hat_angle != HAT_CENTRED) begin
               held_hat = s.hat_angle;
               r.event_valid = 1'b1;
               r.event_kind = KIND_HAT;
               if (s.hat_angle < HAT_UP_LOW || s.hat_angle > HAT_UP_HIGH)
                  r.hat_direction = DIR_UP;
               else if (s.hat_angle < HAT_RIGHT_LOW)
                  r.hat_direction = DIR_RIGHT;
               else if (s.hat_angle < HAT_DOWN_LOW)
                  r.hat_direction = DIR_DOWN;
               else
                  r.hat_direction = DIR_LEFT;
            end else begin
               held_hat = s.hat_angle;
               for (int i = 0; i < AXES_SEEN; i++) begin
                  if (!r.event_valid) begin
                     v = s.axis[i];
                     span = (v > centre) ? v - centre : centre - v;
                     out_now = span > dead_zone;
                     if (out_now && !axis_flag[i]) begin
                        axis_flag[i] = 1'b1;
                        r.event_valid = 1'b1;
                        r.event_kind = KIND_AXIS;
                        r.axis_number = 3'(i);
                        r.axis_positive = v > centre;
                     end else begin
                        axis_flag[i] = out_now;
                     end
                  end
               end
            end
            if (r.event_valid) armed = 1'b0;
         end
         default: ;
      endcase
      r.armed_now = armed;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         centre = AXIS_CENTER_RST;
         dead_zone = DEAD_ZONE_RST;
         armed = 1'b0;
         held_buttons = '0;
         held_hat = HAT_CENTRED;
         axis_flag = '0;
         expected_events.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_AXIS_CENTER) centre = csr_wdata;
            else dead_zone = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            got.event_valid = rsp_event_valid;
            got.event_kind = rsp_event_kind;
            got.button_number = rsp_button_number;
            got.hat_direction = rsp_hat_direction;
            got.axis_number = rsp_axis_number;
            got.axis_positive = rsp_axis_positive;
            got.armed_now = rsp_armed_now;
            if (expected_events.size() == 0) begin
               $display("%0t: result word with none expected, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_valid", 32'(want.event_valid), 32'(got.event_valid));
               check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
               check_field("button_number", 32'(want.button_number),
                           32'(got.button_number));
               check_field("hat_direction", 32'(want.hat_direction),
                           32'(got.hat_direction));
               check_field("axis_number", 32'(want.axis_number), 32'(got.axis_number));
               check_field("axis_positive", 32'(want.axis_positive),
                           32'(got.axis_positive));
               check_field("armed_now", 32'(want.armed_now), 32'(got.armed_now));
            end
         end
         if (req_valid && !req_stall) begin
            word_in.op = req_op;
            word_in.buttons = req_buttons;
            word_in.hat_angle = req_hat_angle;
            word_in.axis[0] = req_axis_x;
            word_in.axis[1] = req_axis_y;
            word_in.axis[2] = req_axis_z;
            word_in.axis[3] = req_axis_r;
            word_in.axis[4] = req_axis_u;
            word_in.axis[5] = req_axis_v;
            predict_event(word_in, want);
            expected_events.push_back(want);
         end
      end
      events_pending <= expected_events.size();
      mismatch_count <= errors;
   end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Capture event detector testbench
// Drives directed and random command words through the capture event
// detector under several axis centre and dead zone settings, with bursty
// requests and patterned result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import gced_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 75;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum {FOCUS_BUTTON, FOCUS_HAT, FOCUS_AXIS, FOCUS_NOISE} focus_type;
   typedef enum {STALL_NONE, STALL_SPARSE, STALL_COMB, STALL_HEAVY} stall_pattern_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [31:0] req_buttons;
   logic [15:0] req_hat_angle;
   logic [15:0] req_axis_x;
   logic [15:0] req_axis_y;
   logic [15:0] req_axis_z;
   logic [15:0] req_axis_r;
   logic [15:0] req_axis_u;
   logic [15:0] req_axis_v;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_event_valid;
   logic [1:0]  rsp_event_kind;
   logic [5:0]  rsp_button_number;
   logic [1:0]  rsp_hat_direction;
   logic [2:0]  rsp_axis_number;
   logic        rsp_axis_positive;
   logic        rsp_armed_now;
   int          events_pending;
   int          mismatch_count;

   logic [15:0] cur_centre = AXIS_CENTER_RST;
   logic [15:0] cur_dz = DEAD_ZONE_RST;
   logic [31:0] last_btns = '0;
   logic [15:0] last_hat = HAT_CENTRED;
   int          burst_left = 0;
   int          stall_left = 0;
   int          cycles = 0;
   stall_pattern_type stall_pattern = STALL_NONE;

   gamepad_capture_event_detector_unit uut (.*);
   gced_event_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_pattern)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_COMB:   rsp_stall <= (stall_left % 9) < 5;
            default:      rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   function automatic logic [15:0] pick_axis();
      int v;
      case ($urandom_range(0, 5))
         0: v = int'(cur_centre);
         1: v = int'(cur_centre) + int'(cur_dz) + int'($urandom_range(0, 2)) - 1;
         2: v = int'(cur_centre) - int'(cur_dz) + int'($urandom_range(0, 2)) - 1;
         3: v = $urandom_range(0, 1) ? 0 : 65535;
         4: v = int'(cur_centre) + int'($urandom_range(0, 2 * cur_dz)) - int'(cur_dz);
         default: v = int'($urandom_range(0, 65535));
      endcase
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [15:0] pick_hat();
      logic [15:0] mark;
      case ($urandom_range(0, 3))
         0: mark = HAT_UP_LOW;
         1: mark = HAT_RIGHT_LOW;
         2: mark = HAT_DOWN_LOW;
         default: mark = HAT_UP_HIGH;
      endcase
      case ($urandom_range(0, 5))
         0, 1: return HAT_CENTRED;
         2: return 16'(int'(mark) + int'($urandom_range(0, 2)) - 1);
         3: return $urandom_range(0, 1) ? 16'd0 : 16'd35999;
         4: return 16'($urandom_range(0, 35999));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_buttons(input logic [31:0] held);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'd1 << $urandom_range(0, 31);
         2: return held;
         3: return held | (32'd1 << $urandom_range(0, 31));
         4: return held & $urandom;
         default: return $urandom;
      endcase
   endfunction

   function automatic sample_type make_poll(input focus_type focus);
      sample_type s;
      s.op = OP_POLL;
      for (int i = 0; i < AXIS_FIELDS; i++) s.axis[i] = pick_axis();
      case (focus)
         FOCUS_BUTTON: begin
            s.buttons = pick_buttons(last_btns);
            s.hat_angle = pick_hat();
         end
         FOCUS_HAT: begin
            s.buttons = ($urandom_range(0, 3) == 0) ? pick_buttons(last_btns) : '0;
            s.hat_angle = pick_hat();
         end
         FOCUS_AXIS: begin
            s.buttons = $urandom_range(0, 1) ? '0 : last_btns;
            s.hat_angle = $urandom_range(0, 1) ? HAT_CENTRED : last_hat;
         end
         default: begin
            s.op = 2'($urandom_range(0, 3));
            s.buttons = $urandom;
            s.hat_angle = 16'($urandom);
            for (int i = 0; i < AXIS_FIELDS; i++) s.axis[i] = 16'($urandom);
         end
      endcase
      if (focus != FOCUS_NOISE) begin
         if ($urandom_range(0, 19) == 0) s.op = OP_CANCEL;
         else if ($urandom_range(0, 24) == 0) s.op = OP_ARM;
      end
      last_btns = s.buttons;
      last_hat = s.hat_angle;
      return s;
   endfunction

   task automatic put_word(input sample_type s);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                    $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= s.op;
      req_buttons <= s.buttons;
      req_hat_angle <= s.hat_angle;
      req_axis_x <= s.axis[0];
      req_axis_y <= s.axis[1];
      req_axis_z <= s.axis[2];
      req_axis_r <= s.axis[3];
      req_axis_u <= s.axis[4];
      req_axis_v <= s.axis[5];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic put_fields(input logic [1:0] op, input logic [31:0] buttons,
                             input logic [15:0] hat, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] v);
      sample_type s;
      s.op = op;
      s.buttons = buttons;
      s.hat_angle = hat;
      for (int i = 0; i < AXIS_FIELDS; i++) s.axis[i] = cur_centre;
      s.axis[0] = x;
      s.axis[1] = y;
      s.axis[5] = v;
      put_word(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_AXIS_CENTER) cur_centre = data;
      else cur_dz = data;
      @(posedge clock);
   endtask

   task automatic random_phase(input int quota);
      int         sent;
      int         pick;
      focus_type  focus;
      sample_type s;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 9);
         focus = (pick < 2) ? FOCUS_BUTTON : (pick < 4) ? FOCUS_HAT :
                 (pick < 8) ? FOCUS_AXIS : FOCUS_NOISE;
         if (focus != FOCUS_NOISE) begin
            s = make_poll(FOCUS_NOISE);
            s.op = OP_ARM;
            put_word(s);
            sent++;
         end
         repeat ($urandom_range(1, 6)) begin
            s = make_poll(focus);
            put_word(s);
            if (s.op != OP_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] centre_set;
      logic [15:0] dz_set;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_AXIS_CENTER;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_op <= OP_POLL;
      req_buttons <= '0;
      req_hat_angle <= HAT_CENTRED;
      req_axis_x <= '0;
      req_axis_y <= '0;
      req_axis_z <= '0;
      req_axis_r <= '0;
      req_axis_u <= '0;
      req_axis_v <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      put_fields(OP_POLL, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd32767, 16'd32767);
      put_fields(OP_UNUSED, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, 32'h8000_0000, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, 32'hFFFF_FFFF, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd0, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd4499, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd4500, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd13500, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd31500, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd31501, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, 16'd31501, 16'd20766, 16'd32767, 16'd32767);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, HAT_CENTRED, 16'd0, 16'd44767, 16'd65535);
      put_fields(OP_ARM, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, '0, HAT_CENTRED, 16'd32767, 16'd20767, 16'd32767);
      put_fields(OP_CANCEL, '0, HAT_CENTRED, 16'd32767, 16'd32767, 16'd32767);
      put_fields(OP_POLL, 32'h0000_0001, 16'd22500, 16'd0, 16'd32767, 16'd32767);
      random_phase(PHASE_WORDS);

      for (int phase = 1; phase < 9; phase++) begin
         case (phase)
            1: begin centre_set = 16'd0;     dz_set = 16'd0;     end
            2: begin centre_set = 16'd65535; dz_set = 16'd32768; end
            3: begin centre_set = 16'd32768; dz_set = 16'd1;     end
            4: begin centre_set = 16'd0;     dz_set = 16'd32768; end
            5: begin centre_set = 16'd65535; dz_set = 16'd0;     end
            default: begin
               centre_set = 16'($urandom);
               dz_set = 16'($urandom_range(0, 32768));
            end
         endcase
         drain();
         write_csr(CSR_AXIS_CENTER, centre_set);
         write_csr(CSR_DEAD_ZONE, dz_set);
         random_phase(PHASE_WORDS);
      end

      drain();
      if (mismatch_count == 0 && events_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/gced_pkg.sv
rtl/core/gced_in_stage.sv
rtl/core/gced_axis_cmp.sv
rtl/core/gced_core.sv
rtl/core/gamepad_capture_event_detector_unit.sv
test/gced_event_checker.sv
test/tb.sv
